// ===== src/paged_prefill_admission_checker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the paged prefill admission checker
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PAGED_PREFILL_ADMISSION_CHECKER_CORE_MACROS_SVH
`define PAGED_PREFILL_ADMISSION_CHECKER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PPAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// next-cycle implication, disabled during reset
`define PPAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define PPAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PPAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/ppac_pkg.sv =====
// ----------------------------------------------------------------------------
// ppac_pkg
// Types and constants shared by the paged prefill admission checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ppac_pkg;

	// rows per page
	localparam int PAGE_CELLS = 256;
	// bits for a page fill of 0..PAGE_CELLS
	localparam int FILL_W = $clog2(PAGE_CELLS + 1);

	localparam logic [FILL_W-1:0] PAGE_FILL = FILL_W'(PAGE_CELLS);
	localparam logic [31:0]       PAGE_ROWS = 32'(PAGE_CELLS);

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_FINISH = 2'd1,
		OP_DECODE = 2'd2
	} ppac_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} ppac_status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] page_index;
		logic [31:0] rows;
	} ppac_cmd_t;

	typedef struct packed {
		logic [31:0]       open_pages;
		logic [FILL_W-1:0] last_fill;
		logic [31:0]       resident_total;
		logic              tail_done;
		logic              decode_on;
	} ppac_state_t;

endpackage

`default_nettype wire

// ===== src/ppac_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ppac_cmd_if
// Command channel: valid/ready handshake with one command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppac_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] page_index;
	logic [31:0] rows;

	modport source (output valid, output opcode, output page_index, output rows,
		input ready);
	modport sink (input valid, input opcode, input page_index, input rows,
		output ready);
endinterface

`default_nettype wire

// ===== src/ppac_res_if.sv =====
// ----------------------------------------------------------------------------
// ppac_res_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppac_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] total_rows;
	logic        decoding;

	modport source (output valid, output status, output total_rows, output decoding,
		input ready);
	modport sink (input valid, input status, input total_rows, input decoding,
		output ready);
endinterface

`default_nettype wire

// ===== src/paged_prefill_admission_checker_core.sv =====
// ----------------------------------------------------------------------------
// paged_prefill_admission_checker_core
// Ordering checker for prefill commands of a paged key/value store.
// ----------------------------------------------------------------------------
// Takes one command per clock cycle, sustained while results are drained, and
// returns one result per command in order: the status, the resident row total
// and the decode flag after the command. A command is registered on
// acceptance in the input register, checked there against the tracking state,
// and its result is registered at the same edge that updates the state. The
// rate is set by the state registers, which take one update per cycle. A
// stalled result holds the next command in the input register; a command
// enters during the stall only while that register is empty, and the input
// then waits.
`default_nettype none
`include "paged_prefill_admission_checker_core_macros.svh"

module paged_prefill_admission_checker_core
	import ppac_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	ppac_cmd_if.sink    cmd,
	ppac_res_if.source  res
);

	logic         valid_s1;
	ppac_cmd_t    cmd_s1;
	logic         adv_s1;
	ppac_state_t  state_q;
	ppac_state_t  state_nxt;
	ppac_status_t status_nxt;
	logic         res_valid_q;
	ppac_status_t status_q;
	logic [31:0]  total_q;
	logic         decoding_q;

	// stage 1 moves on when the result register is free or being drained
	assign adv_s1    = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= '{opcode: cmd.opcode, page_index: cmd.page_index, rows: cmd.rows};
		end
	end

	ppac_eval u_eval (
		.cmd    (cmd_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.status (status_nxt)
	);

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q   <= status_nxt;
			total_q    <= state_nxt.resident_total;
			decoding_q <= state_nxt.decode_on;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = status_q;
	assign res.total_rows = total_q;
	assign res.decoding   = decoding_q;

	// checks
	`PPAC_ASSERT_IMPL(a_fill_range, clk, arst_n, 1'b1, state_q.last_fill <= PAGE_FILL, "last page fill above page size")
	`PPAC_ASSERT_NEXT(a_decode_sticky, clk, arst_n, state_q.decode_on, state_q.decode_on, "decode flag cleared")
	`PPAC_ASSERT_IMPL(a_empty_store, clk, arst_n, state_q.open_pages == 32'd0, (state_q.last_fill == '0) && (state_q.resident_total == 32'd0), "rows present with no page open")
	`PPAC_ASSERT_NEXT(a_result_follows, clk, arst_n, adv_s1, res_valid_q, "checked command produced no result")

endmodule

`default_nettype wire

// ===== src/ppac_eval.sv =====
// ----------------------------------------------------------------------------
// ppac_eval
// Command checker: status and next tracking state for one command.
// ----------------------------------------------------------------------------
`default_nettype none

module ppac_eval
	import ppac_pkg::*;
(
	input  ppac_cmd_t    cmd,
	input  ppac_state_t  cur,
	output ppac_state_t  nxt,
	output ppac_status_t status
);

	logic [31:0]       pc_new;
	logic [FILL_W-1:0] fill_base;
	logic              page_ok;
	logic              rows_bad;
	logic [FILL_W:0]   fill_sum;
	logic [32:0]       res_sum;

	// page selection for append: open first page, open next page, or stay on last
	always_comb begin
		pc_new    = cur.open_pages;
		fill_base = cur.last_fill;
		page_ok   = 1'b0;
		if (cur.open_pages == 32'd0) begin
			page_ok   = (cmd.page_index == 32'd0);
			pc_new    = 32'd1;
			fill_base = '0;
		end else if (cmd.page_index >= cur.open_pages) begin
			page_ok   = (cmd.page_index == cur.open_pages) &&
				(cur.last_fill == PAGE_FILL) && (cur.open_pages != '1);
			pc_new    = cur.open_pages + 32'd1;
			fill_base = '0;
		end else begin
			page_ok = (cmd.page_index == cur.open_pages - 32'd1);
		end
	end

	// row count range and the two sums
	assign rows_bad = (cmd.rows == 32'd0) || (cmd.rows > PAGE_ROWS);
	assign fill_sum = {1'b0, fill_base} + {1'b0, cmd.rows[FILL_W-1:0]};
	assign res_sum  = {1'b0, cur.resident_total} + {1'b0, cmd.rows};

	// command decode; invalid commands leave state untouched
	always_comb begin
		nxt    = cur;
		status = ST_OK;
		case (ppac_op_t'(cmd.opcode))
			OP_APPEND: begin
				if (cur.decode_on || rows_bad || !page_ok) begin
					status = ST_INVALID;
				end else begin
					// page opening is kept even on overflow
					nxt.open_pages = pc_new;
					if (fill_sum > {1'b0, PAGE_FILL}) begin
						nxt.last_fill = fill_base;
						status        = ST_OVERFLOW;
					end else begin
						nxt.last_fill = fill_sum[FILL_W-1:0];
						if (res_sum[32]) begin
							status = ST_OVERFLOW;
						end else begin
							nxt.resident_total = res_sum[31:0];
							nxt.tail_done      = 1'b0;
						end
					end
				end
			end
			OP_FINISH: begin
				if (cur.decode_on || cur.open_pages == 32'd0 || cur.last_fill == '0) begin
					status = ST_INVALID;
				end else begin
					nxt.tail_done = 1'b1;
				end
			end
			OP_DECODE: begin
				if (cur.decode_on || cur.open_pages == 32'd0 || cur.last_fill == '0 ||
					(cur.last_fill != PAGE_FILL && !cur.tail_done)) begin
					status = ST_INVALID;
				end else begin
					nxt.decode_on = 1'b1;
				end
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/ppac_status_checker.sv =====
// ----------------------------------------------------------------------------
// ppac_status_checker
// Watches the command and result channels of the paged prefill admission
// checker. It tracks the paging state, predicts each command's status,
// resident row total and decode flag, and compares every result in order.
// ----------------------------------------------------------------------------
module ppac_status_checker
	import ppac_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ppac_cmd_if  cmd,
	ppac_res_if  res,
	output int   fail_count,
	output int   pending,
	output int   results_checked,
	output int   overflow_seen,
	output int   invalid_seen
);

	typedef struct packed {
		ppac_status_t status;
		logic [31:0]  total_rows;
		logic         decoding;
	} answer_t;

	// answers owed by the block, oldest first
	answer_t answers_due[$];

	// tracked paging state
	logic [31:0]       pages_open;
	logic [FILL_W-1:0] tail_fill;
	logic [31:0]       rows_resident;
	logic              tail_closed;
	logic              decode_live;

	// append rows to the tail page, opening the next page when the tail is full
	function automatic ppac_status_t try_append(logic [31:0] page, logic [31:0] nrows);
		if (decode_live || nrows == 32'd0 || nrows > PAGE_ROWS)
			return ST_INVALID;
		if (pages_open == 32'd0) begin
			if (page != 32'd0)
				return ST_INVALID;
			pages_open = 32'd1;
			tail_fill  = '0;
		end else if (page >= pages_open) begin
			if (page != pages_open || tail_fill != PAGE_FILL || pages_open == '1)
				return ST_INVALID;
			pages_open = pages_open + 32'd1;
			tail_fill  = '0;
		end else if (page + 32'd1 != pages_open) begin
			return ST_INVALID;
		end
		// page opening above stays even if the rows do not fit
		if (32'(tail_fill) > PAGE_ROWS - nrows)
			return ST_OVERFLOW;
		tail_fill = tail_fill + nrows[FILL_W-1:0];
		// fill update stays even if the total would wrap
		if (rows_resident > 32'hFFFF_FFFF - nrows)
			return ST_OVERFLOW;
		rows_resident = rows_resident + nrows;
		tail_closed   = 1'b0;
		return ST_OK;
	endfunction

	function automatic ppac_status_t try_finish();
		if (decode_live || pages_open == 32'd0 || tail_fill == '0)
			return ST_INVALID;
		tail_closed = 1'b1;
		return ST_OK;
	endfunction

	// decode needs a full tail page or a finished partial one
	function automatic ppac_status_t try_decode();
		if (decode_live || pages_open == 32'd0 || tail_fill == '0 ||
			(tail_fill != PAGE_FILL && !tail_closed))
			return ST_INVALID;
		decode_live = 1'b1;
		return ST_OK;
	endfunction

	function automatic answer_t admit_command(logic [1:0] op, logic [31:0] page,
		logic [31:0] nrows);
		answer_t a;
		case (op)
			OP_APPEND: a.status = try_append(page, nrows);
			OP_FINISH: a.status = try_finish();
			OP_DECODE: a.status = try_decode();
			default:   a.status = ST_INVALID;
		endcase
		a.total_rows = rows_resident;
		a.decoding   = decode_live;
		return a;
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		fail_count++;
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
	endfunction

	// compare result transactions first, then predict the accepted command
	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		if (!arst_n) begin
			answers_due.delete();
			pages_open      = '0;
			tail_fill       = '0;
			rows_resident   = '0;
			tail_closed     = 1'b0;
			decode_live     = 1'b0;
			fail_count      = 0;
			results_checked = 0;
			overflow_seen   = 0;
			invalid_seen    = 0;
			pending        <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (answers_due.size() == 0) begin
					flag_mismatch("unexpected result, status", '0, res.status);
				end else begin
					want = answers_due.pop_front();
					if (res.status !== want.status)
						flag_mismatch("status", want.status, res.status);
					if (res.total_rows !== want.total_rows)
						flag_mismatch("total_rows", want.total_rows, res.total_rows);
					if (res.decoding !== want.decoding)
						flag_mismatch("decoding", want.decoding, res.decoding);
					results_checked++;
					if (want.status == ST_OVERFLOW)
						overflow_seen++;
					if (want.status == ST_INVALID)
						invalid_seen++;
				end
			end
			if (cmd.valid && cmd.ready)
				answers_due = {answers_due,
					admit_command(cmd.opcode, cmd.page_index, cmd.rows)};
			pending <= answers_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the paged prefill admission checker.
// A directed opening walks the illegal orderings and page edges, random
// prefill traffic follows with malformed commands mixed in, and decode is
// entered at the end. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
	import ppac_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 550;
	localparam int CALM_TAIL    = 80;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	ppac_cmd_if cmd();
	ppac_res_if res();

	int fail_count;
	int pending;
	int results_checked;
	int overflow_seen;
	int invalid_seen;

	int cycles = 0;
	bit calm   = 1'b0;
	int n_append, n_finish, n_decode, n_unused;

	// stimulus-side view of the paging state, for well-formed commands
	int unsigned sh_pages;
	int          sh_fill;
	bit          sh_tail;

	paged_prefill_admission_checker_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	ppac_status_checker status_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.res             (res),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.overflow_seen   (overflow_seen),
		.invalid_seen    (invalid_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: ready in random bursts, steady in the last part
	initial begin
		res.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 3) == 0) begin
				res.ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// rows from 1 to hi, leaning on both ends
	function automatic logic [31:0] pick_rows(int hi);
		case ($urandom_range(0, 7))
			0:       return 32'd1;
			1:       return 32'(hi);
			default: return 32'($urandom_range(1, hi));
		endcase
	endfunction

	// one command transaction; valid stays high on return
	task automatic put_cmd(input logic [1:0] op, input logic [31:0] page,
		input logic [31:0] nrows);
		cmd.valid      <= 1'b1;
		cmd.opcode     <= op;
		cmd.page_index <= page;
		cmd.rows       <= nrows;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		case (op)
			OP_APPEND: n_append++;
			OP_FINISH: n_finish++;
			OP_DECODE: n_decode++;
			default:   n_unused++;
		endcase
	endtask

	// hold off the sender until every result is back
	task automatic drain_wait();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int          roll;
		int          gap_pct;
		int          room;
		logic [31:0] r;

		arst_n         <= 1'b0;
		cmd.valid      <= 1'b0;
		cmd.opcode     <= OP_APPEND;
		cmd.page_index <= '0;
		cmd.rows       <= '0;
		gap_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing resident yet: every command is refused
		put_cmd(OP_FINISH, '0, '0);
		put_cmd(OP_DECODE, '0, '0);
		put_cmd(OP_APPEND, 32'd0, 32'd0);
		put_cmd(OP_APPEND, 32'd0, PAGE_ROWS + 32'd1);
		put_cmd(OP_APPEND, 32'd0, 32'hFFFF_FFFF);
		put_cmd(OP_APPEND, 32'hFFFF_FFFF, 32'd1);
		put_cmd(OP_APPEND, 32'd1, 32'd1);
		put_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// page 0 opens, then the tail page edges
		put_cmd(OP_APPEND, 32'd0, 32'd1);
		put_cmd(OP_APPEND, 32'd1, 32'd1);
		put_cmd(OP_DECODE, '0, '0);
		put_cmd(OP_FINISH, '0, '0);
		put_cmd(OP_APPEND, 32'd0, PAGE_ROWS);
		put_cmd(OP_APPEND, 32'd0, PAGE_ROWS - 32'd1);
		put_cmd(OP_APPEND, 32'd0, 32'd1);
		put_cmd(OP_FINISH, '0, '0);
		put_cmd(OP_APPEND, 32'd2, 32'd5);
		put_cmd(OP_APPEND, 32'd1, PAGE_ROWS);
		put_cmd(OP_APPEND, 32'd0, 32'd1);
		put_cmd(OP_APPEND, 32'd2, 32'd100);
		sh_pages = 3;
		sh_fill  = 100;
		sh_tail  = 1'b0;
		drain_wait();

		// random prefill traffic
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 15;
					default: gap_pct = 50;
				endcase
			end
			if (i == RANDOM_ITEMS - CALM_TAIL)
				calm = 1'b1;
			if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
				cmd.valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else if (!calm && $urandom_range(1, 80) == 1) begin
				drain_wait();
			end

			roll = $urandom_range(1, 100);
			if (roll <= 50) begin
				if (sh_fill == PAGE_CELLS) begin
					// tail full: open the next page
					r = pick_rows(PAGE_CELLS);
					put_cmd(OP_APPEND, sh_pages, r);
					sh_pages++;
					sh_fill = int'(r);
					sh_tail = 1'b0;
				end else begin
					room = PAGE_CELLS - sh_fill;
					if ($urandom_range(0, 5) == 0) begin
						// too many rows for the tail: overflow, no change
						put_cmd(OP_APPEND, sh_pages - 1, 32'($urandom_range(room + 1, PAGE_CELLS)));
					end else begin
						r = ($urandom_range(0, 3) == 0) ? 32'(room) : pick_rows(room);
						put_cmd(OP_APPEND, sh_pages - 1, r);
						sh_fill += int'(r);
						sh_tail = 1'b0;
					end
				end
			end else if (roll <= 62 || (roll <= 68 && (sh_fill == PAGE_CELLS || sh_tail))) begin
				put_cmd(OP_FINISH, $urandom, $urandom);
				sh_tail = 1'b1;
			end else if (roll <= 68) begin
				// partial tail not finished: decode is refused
				put_cmd(OP_DECODE, $urandom, $urandom);
			end else begin
				case ($urandom_range(0, 5))
					0: put_cmd(OP_APPEND, ($urandom_range(0, 1) != 0) ? sh_pages - 1 : $urandom,
						32'd0);
					1: put_cmd(OP_APPEND, sh_pages - 1,
						32'($urandom_range(PAGE_CELLS + 1, 32'hFFFF_FFFF)));
					2: put_cmd(OP_APPEND, $urandom | 32'h8000_0000, pick_rows(PAGE_CELLS));
					3: put_cmd(OP_APPEND, (sh_fill == PAGE_CELLS) ? sh_pages + 1 : sh_pages,
						pick_rows(PAGE_CELLS));
					4: begin
						if (sh_pages >= 2)
							put_cmd(OP_APPEND, $urandom_range(0, sh_pages - 2),
								pick_rows(PAGE_CELLS));
						else
							put_cmd(OP_UNUSED, $urandom, $urandom);
					end
					default: put_cmd(OP_UNUSED, $urandom, $urandom);
				endcase
			end
		end

		// enter decode, finishing a partial tail first; then everything is refused
		if (sh_fill != PAGE_CELLS && !sh_tail) begin
			put_cmd(OP_DECODE, '0, '0);
			put_cmd(OP_FINISH, '0, '0);
		end
		put_cmd(OP_DECODE, '0, '0);
		put_cmd(OP_DECODE, '0, '0);
		put_cmd(OP_FINISH, '0, '0);
		put_cmd(OP_APPEND, sh_pages - 1, 32'd1);
		put_cmd(OP_UNUSED, '0, '0);
		repeat (10)
			put_cmd(2'($urandom_range(0, 3)), $urandom, $urandom);

		drain_wait();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands: %0d append, %0d finish, %0d decode, %0d unused opcode.",
			n_append + n_finish + n_decode + n_unused, n_append, n_finish, n_decode, n_unused);
		$display("Checked %0d results over %0d pages, with %0d refusals and %0d overflows.",
			results_checked, sh_pages, invalid_seen, overflow_seen);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/ppac_pkg.sv
src/ppac_cmd_if.sv
src/ppac_res_if.sv
src/ppac_eval.sv
src/paged_prefill_admission_checker_core.sv
tb/ppac_status_checker.sv
tb/tb.sv
